### rtl/fnt_pkg.sv
// Package for the feed text normalizer: queue entry type, front state codes,
// character constants and queue sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fnt_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LATIN = 8'hC3;

    // Entity prefix ids held by the front; 0 means no prefix.
    localparam logic [4:0] PFX_NONE = 5'd0;
    localparam logic [4:0] PFX_AMP  = 5'd1;

    // tail: entry comes from the final input transfer of its text
    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       last;
        logic       tail;
    } fnt_entry_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_RELEASE,
        FR_HELD,
        FR_END_RELEASE
    } fnt_front_state_t;

    typedef enum logic [1:0] {
        STEP_ADV,
        STEP_ENT,
        STEP_MISS
    } fnt_step_kind_t;

    typedef struct packed {
        fnt_step_kind_t kind;
        logic [4:0]     nxt;
        logic [7:0]     val;
    } fnt_step_t;

endpackage

`default_nettype wire

### rtl/fnt_queue.sv
// Short FIFO of decoded-byte entries between front and back.
// Depends on fnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnt_queue
    import fnt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire fnt_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output logic            head_valid,
    output fnt_entry_t      head_entry
);

    fnt_entry_t     mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

### rtl/fnt_front.sv
// Front part: accepts raw bytes, tracks entity prefixes, decodes entities and
// releases unmatched prefixes one byte per transfer. Depends on fnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnt_front
    import fnt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // in_byte
    input  wire logic       s_axis_tlast,   // in_last
    output logic            push,
    output fnt_entry_t      push_entry,
    input  wire logic       q_full
);

    function automatic logic [2:0] prefix_len(input logic [4:0] id);
        case (id)
            5'd1:                          prefix_len = 3'd1;
            5'd2, 5'd8, 5'd10, 5'd12, 5'd16: prefix_len = 3'd2;
            5'd3, 5'd5, 5'd9, 5'd11, 5'd13, 5'd17: prefix_len = 3'd3;
            5'd4, 5'd6, 5'd14, 5'd18:      prefix_len = 3'd4;
            5'd7, 5'd15:                   prefix_len = 3'd5;
            default:                       prefix_len = 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] prefix_char(input logic [4:0] id, input logic [2:0] idx);
        logic [4:0][7:0] t;
        case (id)
            5'd1:    t = {"&", 32'h0};
            5'd2:    t = {"&a", 24'h0};
            5'd3:    t = {"&am", 16'h0};
            5'd4:    t = {"&amp", 8'h0};
            5'd5:    t = {"&ap", 16'h0};
            5'd6:    t = {"&apo", 8'h0};
            5'd7:    t = "&apos";
            5'd8:    t = {"&l", 24'h0};
            5'd9:    t = {"&lt", 16'h0};
            5'd10:   t = {"&g", 24'h0};
            5'd11:   t = {"&gt", 16'h0};
            5'd12:   t = {"&q", 24'h0};
            5'd13:   t = {"&qu", 16'h0};
            5'd14:   t = {"&quo", 8'h0};
            5'd15:   t = "&quot";
            5'd16:   t = {"&#", 24'h0};
            5'd17:   t = {"&#3", 16'h0};
            5'd18:   t = {"&#39", 8'h0};
            default: t = '0;
        endcase
        prefix_char = t[3'd4 - idx];
    endfunction

    function automatic fnt_step_t entity_step(input logic [4:0] id, input logic [7:0] c);
        fnt_step_t s;
        s.kind = STEP_MISS;
        s.nxt  = PFX_NONE;
        s.val  = 8'h00;
        case (id)
            5'd1:
            begin
                if (c == "a")      begin s.kind = STEP_ADV; s.nxt = 5'd2;  end
                else if (c == "l") begin s.kind = STEP_ADV; s.nxt = 5'd8;  end
                else if (c == "g") begin s.kind = STEP_ADV; s.nxt = 5'd10; end
                else if (c == "q") begin s.kind = STEP_ADV; s.nxt = 5'd12; end
                else if (c == "#") begin s.kind = STEP_ADV; s.nxt = 5'd16; end
            end
            5'd2:
            begin
                if (c == "m")      begin s.kind = STEP_ADV; s.nxt = 5'd3; end
                else if (c == "p") begin s.kind = STEP_ADV; s.nxt = 5'd5; end
            end
            5'd3:  if (c == "p") begin s.kind = STEP_ADV; s.nxt = 5'd4;  end
            // decoded ampersand opens a new prefix
            5'd4:  if (c == ";") begin s.kind = STEP_ADV; s.nxt = PFX_AMP; end
            5'd5:  if (c == "o") begin s.kind = STEP_ADV; s.nxt = 5'd6;  end
            5'd6:  if (c == "s") begin s.kind = STEP_ADV; s.nxt = 5'd7;  end
            5'd7:  if (c == ";") begin s.kind = STEP_ENT; s.val = "'";   end
            5'd8:  if (c == "t") begin s.kind = STEP_ADV; s.nxt = 5'd9;  end
            5'd9:  if (c == ";") begin s.kind = STEP_ENT; s.val = "<";   end
            5'd10: if (c == "t") begin s.kind = STEP_ADV; s.nxt = 5'd11; end
            5'd11: if (c == ";") begin s.kind = STEP_ENT; s.val = ">";   end
            5'd12: if (c == "u") begin s.kind = STEP_ADV; s.nxt = 5'd13; end
            5'd13: if (c == "o") begin s.kind = STEP_ADV; s.nxt = 5'd14; end
            5'd14: if (c == "t") begin s.kind = STEP_ADV; s.nxt = 5'd15; end
            5'd15: if (c == ";") begin s.kind = STEP_ENT; s.val = "\"";  end
            5'd16: if (c == "3") begin s.kind = STEP_ADV; s.nxt = 5'd17; end
            5'd17: if (c == "9") begin s.kind = STEP_ADV; s.nxt = 5'd18; end
            5'd18: if (c == ";") begin s.kind = STEP_ENT; s.val = "'";   end
            default: s.kind = STEP_MISS;
        endcase
        return s;
    endfunction

    fnt_front_state_t state_reg, state_next;
    logic [4:0]       prog_reg, prog_next;
    logic [2:0]       idx_reg, idx_next;
    logic [7:0]       held_byte_reg, held_byte_next;
    logic             held_last_reg, held_last_next;
    logic             accept;
    logic             rel_done;
    logic [7:0]       rel_char;
    fnt_step_t        step;

    assign s_axis_tready = (state_reg == FR_IDLE) && !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign step          = entity_step(prog_reg, s_axis_tdata);
    assign rel_char      = prefix_char(prog_reg, idx_reg);
    assign rel_done      = (idx_reg == prefix_len(prog_reg) - 3'd1);

    always_comb
    begin
        state_next     = state_reg;
        prog_next      = prog_reg;
        idx_next       = idx_reg;
        held_byte_next = held_byte_reg;
        held_last_next = held_last_reg;
        push           = 1'b0;
        push_entry     = '{has_byte: 1'b1, data: s_axis_tdata, last: s_axis_tlast,
                           tail: s_axis_tlast};
        case (state_reg)
            FR_IDLE:
            begin
                idx_next = 3'd0;
                if (accept)
                begin
                    if (s_axis_tdata == CH_NUL)
                    begin
                        if (s_axis_tlast)
                        begin
                            if (prog_reg != PFX_NONE)
                            begin
                                state_next = FR_END_RELEASE;
                            end
                            else
                            begin
                                push       = 1'b1;
                                push_entry = '{has_byte: 1'b0, data: CH_NUL, last: 1'b1,
                                               tail: 1'b1};
                            end
                        end
                    end
                    else if (prog_reg == PFX_NONE)
                    begin
                        if (s_axis_tdata == CH_AMP)
                        begin
                            prog_next = PFX_AMP;
                            if (s_axis_tlast)
                            begin
                                state_next = FR_END_RELEASE;
                            end
                        end
                        else
                        begin
                            push = 1'b1;
                        end
                    end
                    else
                    begin
                        case (step.kind)
                            STEP_ADV:
                            begin
                                prog_next = step.nxt;
                                if (s_axis_tlast)
                                begin
                                    state_next = FR_END_RELEASE;
                                end
                            end
                            STEP_ENT:
                            begin
                                prog_next       = PFX_NONE;
                                push            = 1'b1;
                                push_entry.data = step.val;
                            end
                            default:
                            begin
                                held_byte_next = s_axis_tdata;
                                held_last_next = s_axis_tlast;
                                state_next     = FR_RELEASE;
                            end
                        endcase
                    end
                end
            end
            FR_RELEASE:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    push_entry = '{has_byte: 1'b1, data: rel_char, last: 1'b0,
                                   tail: held_last_reg};
                    idx_next   = idx_reg + 3'd1;
                    if (rel_done)
                    begin
                        prog_next  = PFX_NONE;
                        idx_next   = 3'd0;
                        state_next = FR_HELD;
                    end
                end
            end
            FR_HELD:
            begin
                if (held_byte_reg == CH_AMP)
                begin
                    prog_next  = PFX_AMP;
                    state_next = held_last_reg ? FR_END_RELEASE : FR_IDLE;
                end
                else if (!q_full)
                begin
                    push       = 1'b1;
                    push_entry = '{has_byte: 1'b1, data: held_byte_reg, last: held_last_reg,
                                   tail: held_last_reg};
                    state_next = FR_IDLE;
                end
            end
            FR_END_RELEASE:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    push_entry = '{has_byte: 1'b1, data: rel_char, last: rel_done,
                                   tail: 1'b1};
                    idx_next   = idx_reg + 3'd1;
                    if (rel_done)
                    begin
                        prog_next  = PFX_NONE;
                        idx_next   = 3'd0;
                        state_next = FR_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            prog_reg  <= PFX_NONE;
            idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            prog_reg  <= prog_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
        held_last_reg <= held_last_next;
    end

endmodule

`default_nettype wire

### rtl/fnt_back.sv
// Back part: folds Latin-1 UTF-8 pairs, collapses whitespace, holds back one
// result to place the end flag, and drives the output register. Depends on fnt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnt_back
    import fnt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       head_valid,
    input  wire fnt_entry_t head_entry,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // out_byte
    output logic            m_axis_tuser,   // out_has_byte
    output logic            m_axis_tlast    // out_last
);

    function automatic logic [7:0] fold_trail(input logic [7:0] n);
        if (n inside {[8'hA0:8'hA5]})                 fold_trail = "a";
        else if (n == 8'hA7)                          fold_trail = "c";
        else if (n inside {[8'hA8:8'hAB]})            fold_trail = "e";
        else if (n inside {[8'hAC:8'hAF]})            fold_trail = "i";
        else if (n == 8'hB0)                          fold_trail = "d";
        else if (n == 8'hB1)                          fold_trail = "n";
        else if (n inside {[8'hB2:8'hB6], 8'hB8})     fold_trail = "o";
        else if (n inside {[8'hB9:8'hBC]})            fold_trail = "u";
        else if (n inside {8'hBD, 8'hBF})             fold_trail = "y";
        else if (n inside {[8'h80:8'h85]})            fold_trail = "A";
        else if (n == 8'h87)                          fold_trail = "C";
        else if (n inside {[8'h88:8'h8B]})            fold_trail = "E";
        else if (n inside {[8'h8C:8'h8F]})            fold_trail = "I";
        else if (n == 8'h91)                          fold_trail = "N";
        else if (n inside {[8'h92:8'h96]})            fold_trail = "O";
        else if (n inside {[8'h99:8'h9C]})            fold_trail = "U";
        else                                          fold_trail = 8'h00;
    endfunction

    logic       pending_reg, pending_next;
    logic       latin_reg, latin_next;
    logic       byte_done_reg, byte_done_next;
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg, hold_byte_next;
    logic       hold_tail_reg, hold_tail_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_has_reg, out_has_next;
    logic       out_last_reg, out_last_next;

    logic [7:0] c, fold;
    logic       em, pend, lat, proceed;
    logic [7:0] ch;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       out_free;

    assign c             = head_entry.data;
    assign fold          = fold_trail(c);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_has_reg;
    assign m_axis_tlast  = out_last_reg;

    // classify one decoded byte against the current fold/space state
    always_comb
    begin
        em      = 1'b0;
        ch      = c;
        pend    = pending_reg;
        lat     = latin_reg;
        proceed = 1'b1;
        if (latin_reg)
        begin
            lat = 1'b0;
            if (fold != 8'h00)
            begin
                em = 1'b1;
                ch = fold;
            end
            else
            begin
                pend = 1'b1;
            end
            if (c inside {[8'h80:8'hBF]})
            begin
                proceed = 1'b0;
            end
        end
        if (proceed)
        begin
            if (c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_SPACE)
            begin
                pend = 1'b1;
            end
            else if (c >= 8'hC0)
            begin
                if (c == CH_LATIN)
                begin
                    lat = 1'b1;
                end
                else
                begin
                    pend = 1'b1;
                end
            end
            else if (!c[7])
            begin
                em = 1'b1;
                ch = c;
            end
        end
    end

    always_comb
    begin
        pending_next    = pending_reg;
        latin_next      = latin_reg;
        byte_done_next  = byte_done_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_tail_next  = hold_tail_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        pop             = 1'b0;
        r_valid         = 1'b0;
        r_byte          = ch;
        if (head_valid && out_free)
        begin
            if (head_entry.has_byte && !byte_done_reg)
            begin
                if (em && pend)
                begin
                    // space first; entry is revisited for the character
                    r_valid      = 1'b1;
                    r_byte       = CH_SPACE;
                    pending_next = 1'b0;
                    latin_next   = latin_reg && (fold != 8'h00);
                end
                else
                begin
                    r_valid      = em;
                    pending_next = pend && !em;
                    latin_next   = lat;
                    if (head_entry.last)
                    begin
                        byte_done_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                if (r_valid)
                begin
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = hold_byte_reg;
                        out_has_next   = 1'b1;
                        out_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_byte_next  = r_byte;
                    hold_tail_next  = head_entry.tail;
                end
            end
            else if (hold_valid_reg && !hold_tail_reg)
            begin
                // held result belongs to an earlier input transfer: send it plain,
                // the end marker follows on its own
                out_valid_next  = 1'b1;
                out_byte_next   = hold_byte_reg;
                out_has_next    = 1'b1;
                out_last_next   = 1'b0;
                hold_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next  = 1'b1;
                out_byte_next   = hold_valid_reg ? hold_byte_reg : CH_NUL;
                out_has_next    = hold_valid_reg;
                out_last_next   = 1'b1;
                hold_valid_next = 1'b0;
                pending_next    = 1'b0;
                latin_next      = 1'b0;
                byte_done_next  = 1'b0;
                pop             = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= 1'b0;
            latin_reg      <= 1'b0;
            byte_done_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pending_reg    <= pending_next;
            latin_reg      <= latin_next;
            byte_done_reg  <= byte_done_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        hold_tail_reg <= hold_tail_next;
        out_byte_reg  <= out_byte_next;
        out_has_reg   <= out_has_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire

### rtl/feed_text_normalizer_core.sv
// Throughput: one byte per cycle while the queue has room and no prefix is being released;
// an unmatched prefix stalls input while it is released, and the back part spends extra
// steps on each pending space and at a text end. A queue entry is registered before it is
// processed; its result is held until the next result or the end of its text is processed.
// Reset (rst_n low, asynchronous): prefix, space and lead state cleared, queue
// and output register empty. Top level; depends on fnt_pkg, fnt_front, fnt_queue, fnt_back.
`timescale 1ns / 1ps
`default_nettype none

module feed_text_normalizer_core
    import fnt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // in_last
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tuser,   // [0] out_has_byte
    output logic            m_axis_tlast    // out_last
);

    logic       push;
    fnt_entry_t push_entry;
    logic       q_full;
    logic       pop;
    logic       head_valid;
    fnt_entry_t head_entry;

    fnt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push          (push),
        .push_entry    (push_entry),
        .q_full        (q_full)
    );

    fnt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    fnt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_entry    (head_entry),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### tb/feed_text_normalizer_core_tb.sv
// Testbench for feed_text_normalizer_core: stream stimulus with an entity/UTF-8/space
// predictor and an in-order scoreboard of expected output transfers.
// Depends on fnt_pkg and the feed_text_normalizer_core RTL.
`timescale 1ns / 1ps

module feed_text_normalizer_core_tb;
    import fnt_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } raw_byte_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       last;
    } exp_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    raw_byte_t  raw_q[$];
    raw_byte_t  text_q[$];
    exp_item_t  clean_q[$];
    exp_item_t  step_q[$];

    logic [47:0] held_txt;
    int          held_len;
    logic        space_held;
    logic        lead_held;

    int err_cnt = 0;
    int phase = 0;
    bit in_took = 0;

    feed_text_normalizer_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    // Entity table, text right-aligned.
    function automatic logic [47:0] ent_text(int e);
        case (e)
            0:       return "&amp;";
            1:       return "&lt;";
            2:       return "&gt;";
            3:       return "&quot;";
            4:       return "&#39;";
            default: return "&apos;";
        endcase
    endfunction

    function automatic int ent_len(int e);
        case (e)
            1, 2:    return 4;
            3, 5:    return 6;
            default: return 5;
        endcase
    endfunction

    function automatic logic [7:0] ent_char(int e);
        case (e)
            0:       return "&";
            1:       return "<";
            2:       return ">";
            3:       return "\"";
            default: return "'";
        endcase
    endfunction

    function automatic logic [7:0] fold_letter(logic [7:0] n);
        if (n >= 8'hA0 && n <= 8'hA5) return "a";
        if (n == 8'hA7) return "c";
        if (n >= 8'hA8 && n <= 8'hAB) return "e";
        if (n >= 8'hAC && n <= 8'hAF) return "i";
        if (n == 8'hB0) return "d";
        if (n == 8'hB1) return "n";
        if ((n >= 8'hB2 && n <= 8'hB6) || n == 8'hB8) return "o";
        if (n >= 8'hB9 && n <= 8'hBC) return "u";
        if (n == 8'hBD || n == 8'hBF) return "y";
        if (n >= 8'h80 && n <= 8'h85) return "A";
        if (n == 8'h87) return "C";
        if (n >= 8'h88 && n <= 8'h8B) return "E";
        if (n >= 8'h8C && n <= 8'h8F) return "I";
        if (n == 8'h91) return "N";
        if (n >= 8'h92 && n <= 8'h96) return "O";
        if (n >= 8'h99 && n <= 8'h9C) return "U";
        return CH_NUL;
    endfunction

    function automatic void put_out(logic [7:0] b);
        if (step_q.size() < 8)
            step_q.push_back('{has_byte: 1'b1, data: b, last: 1'b0});
    endfunction

    function automatic void put_char(logic [7:0] b);
        if (space_held)
        begin
            put_out(CH_SPACE);
            space_held = 1'b0;
        end
        put_out(b);
    endfunction

    function automatic void clean_byte(logic [7:0] c);
        logic [7:0] a;
        if (lead_held)
        begin
            a = fold_letter(c);
            lead_held = 1'b0;
            if (a != CH_NUL) put_char(a);
            else space_held = 1'b1;
            if (c >= 8'h80 && c <= 8'hBF) return;
        end
        if (c == CH_LF || c == CH_CR || c == CH_TAB || c == CH_SPACE)
            space_held = 1'b1;
        else if (c >= 8'hC0)
        begin
            if (c == CH_LATIN) lead_held = 1'b1;
            else space_held = 1'b1;
        end
        else if (c < 8'h80)
            put_char(c);
    endfunction

    function automatic void flush_held();
        logic [47:0] t;
        int n;
        t = held_txt;
        n = held_len;
        held_txt = '0;
        held_len = 0;
        for (int i = n - 1; i >= 0; i--)
            clean_byte(t[8*i +: 8]);
    endfunction

    function automatic void decode_byte(logic [7:0] c);
        logic [47:0] cand;
        int clen;
        if (held_len != 0)
        begin
            cand = {held_txt[39:0], c};
            clen = held_len + 1;
            for (int e = 0; e < 6; e++)
            begin
                if (ent_len(e) == clen && ent_text(e) == cand)
                begin
                    held_txt = '0;
                    held_len = 0;
                    if (ent_char(e) == CH_AMP)
                    begin
                        held_txt = 48'(CH_AMP);
                        held_len = 1;
                    end
                    else
                        clean_byte(ent_char(e));
                    return;
                end
            end
            for (int e = 0; e < 6; e++)
            begin
                if (ent_len(e) > clen && (ent_text(e) >> (8 * (ent_len(e) - clen))) == cand)
                begin
                    held_txt = cand;
                    held_len = clen;
                    return;
                end
            end
            flush_held();
        end
        if (c == CH_AMP)
        begin
            held_txt = 48'(CH_AMP);
            held_len = 1;
        end
        else
            clean_byte(c);
    endfunction

    function automatic void predict_clean(logic [7:0] c, logic last);
        step_q.delete();
        if (c != CH_NUL) decode_byte(c);
        if (last)
        begin
            flush_held();
            lead_held = 1'b0;
            space_held = 1'b0;
            if (step_q.size() > 0)
                step_q[step_q.size() - 1].last = 1'b1;
            else
                step_q.push_back('{has_byte: 1'b0, data: CH_NUL, last: 1'b1});
        end
        foreach (step_q[i]) clean_q.push_back(step_q[i]);
    endfunction

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // Stimulus helpers
    task automatic add_byte(input logic [7:0] b);
        text_q.push_back('{b: b, last: 1'b0});
    endtask

    task automatic add_str(input logic [47:0] s, input int n);
        for (int i = n - 1; i >= 0; i--) add_byte(s[8*i +: 8]);
    endtask

    task automatic commit_text();
        text_q[text_q.size() - 1].last = 1'b1;
        foreach (text_q[i]) raw_q.push_back(text_q[i]);
        text_q.delete();
    endtask

    task automatic add_token();
        int e;
        int k;
        e = $urandom_range(0, 5);
        case ($urandom_range(0, 9))
            0: add_str(ent_text(e), ent_len(e));
            1:
            begin
                k = $urandom_range(1, ent_len(e) - 1);
                add_str(ent_text(e) >> (8 * (ent_len(e) - k)), k);
            end
            2:
            begin
                add_str("&amp;", 5);
                add_str(ent_text(e), ent_len(e) - 1);
            end
            3:
            begin
                add_byte(CH_LATIN);
                add_byte(8'($urandom_range(8'h80, 8'hBF)));
            end
            4:
            begin
                add_byte(CH_LATIN);
                add_byte(8'($urandom_range(0, 255)));
            end
            5:
            begin
                k = $urandom_range(1, 3);
                repeat (k)
                begin
                    case ($urandom_range(0, 3))
                        0:       add_byte(CH_TAB);
                        1:       add_byte(CH_LF);
                        2:       add_byte(CH_CR);
                        default: add_byte(CH_SPACE);
                    endcase
                end
            end
            6, 7: add_byte(8'($urandom_range(8'h21, 8'h7E)));
            8:    add_byte(8'($urandom_range(0, 255)));
            default: add_byte(8'($urandom_range(8'h80, 8'hFF)));
        endcase
    endtask

    // Driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(s_axis_tvalid && !in_took))
            begin
                in_took = 0;
                if (raw_q.size() != 0 &&
                    !((phase == 1 && $urandom_range(0, 99) < 81) ||
                      (phase == 3 && $urandom_range(0, 99) < 6)))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= raw_q[0].b;
                    s_axis_tlast  <= raw_q[0].last;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= !((phase == 2 && $urandom_range(0, 99) < 81) ||
                               (phase == 3 && $urandom_range(0, 99) < 6));
        end
    end

    // Input transfers feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_clean(s_axis_tdata, s_axis_tlast);
            void'(raw_q.pop_front());
            in_took = 1;
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        exp_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (clean_q.size() == 0)
                report($sformatf("unexpected transfer data=%02h user=%0b last=%0b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast));
            else
            begin
                want = clean_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report($sformatf("data %02h, want %02h", m_axis_tdata, want.data));
                if (m_axis_tuser !== want.has_byte)
                    report($sformatf("has_byte %0b, want %0b", m_axis_tuser, want.has_byte));
                if (m_axis_tlast !== want.last)
                    report($sformatf("last %0b, want %0b (data %02h)",
                                     m_axis_tlast, want.last, want.data));
            end
        end
    end

    initial
    begin
        #3ms;
        $display("** feed_text_normalizer_core: FAILED **");
        $finish;
    end

    initial
    begin
        held_txt = '0;
        held_len = 0;
        space_held = 1'b0;
        lead_held = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            int n;
            phase = ph;
            if (ph == 0)
            begin
                // leading space, chained entity, folded letter, NUL, stray and lead bytes
                add_byte(CH_SPACE);
                add_str("&amp;", 5);
                add_str("lt;", 3);
                add_byte(CH_LATIN);
                add_byte(8'hA9);
                add_byte(CH_NUL);
                add_byte(8'h80);
                add_byte(8'hE2);
                add_byte("A");
                add_byte(8'h01);
                add_byte(8'h7F);
                commit_text();
                // unmapped non-continuation trail, prefix flushed at end by NUL+last
                add_byte(CH_LATIN);
                add_byte("A");
                add_str("&qu", 3);
                add_byte(CH_NUL);
                commit_text();
                // lead at end
                add_byte(CH_LATIN);
                commit_text();
                // unmapped continuation trail, trailing space only: bare end marker
                add_byte(8'hFF);
                add_byte(CH_LATIN);
                add_byte(8'hBE);
                add_byte(CH_LF);
                commit_text();
            end
            n = 0;
            while (n < 24)
            begin
                repeat ($urandom_range(1, 8)) add_token();
                if ($urandom_range(0, 7) == 0) add_byte(CH_NUL);
                n += text_q.size();
                commit_text();
            end
            while (raw_q.size() != 0 || clean_q.size() != 0) @(posedge clk);
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0 && clean_q.size() == 0)
            $display("** feed_text_normalizer_core: PASSED **");
        else
            $display("** feed_text_normalizer_core: FAILED **");
        $finish;
    end

endmodule
